// ----- rtl/aes_pkg.sv -----
// AES-128 package: S-box, GF(2^8) helpers, round transforms and the key schedule step.
// Used by every module of the encryption pipeline.
package aes_pkg;

  localparam int NumRounds = 10;

  typedef logic [127:0] blk_t;

  typedef logic [7:0] rcon_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n sits at bits 127-8n .. 120-8n
  function automatic logic [7:0] byte_at(input blk_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t b);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = sbox(byte_at(b, ((c + r) % 4)*4 + r));
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t b);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(b, c*4);
      a1 = byte_at(b, c*4 + 1);
      a2 = byte_at(b, c*4 + 2);
      a3 = byte_at(b, c*4 + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127 - 8*(c*4 + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127 - 8*(c*4 + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127 - 8*(c*4 + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // one step of the key schedule: round key k to the next, using rcon rc
  function automatic blk_t next_key(input blk_t k, input rcon_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic rcon_t rcon(input int round);
    rcon_t r;
    unique case (round)
      1: r = 8'h01; 2: r = 8'h02; 3: r = 8'h04; 4: r = 8'h08; 5: r = 8'h10;
      6: r = 8'h20; 7: r = 8'h40; 8: r = 8'h80; 9: r = 8'h1b; 10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/aes_round_cell.sv -----
// One round cell of the AES pipeline: round transform plus its key schedule step.
// Depends on aes_pkg.
module aes_round_cell
  import aes_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  last,
  input  rcon_t rc,
  input  logic  in_valid,
  input  blk_t  in_state,
  input  blk_t  in_key,
  output logic  out_valid,
  output blk_t  out_state,
  output blk_t  out_key
);

  blk_t key_n;
  blk_t st_n;
  blk_t sh;

  always_comb begin
    key_n = next_key(in_key, rc);
    sh    = sub_shift(in_state);
    st_n  = (last ? sh : mix_columns(sh)) ^ key_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= st_n;
      out_key   <= key_n;
    end
  end

endmodule

// ----- rtl/aes128_block_encrypt_unit.sv -----
// Top level of the AES-128 encryption pipeline: key registers, input stage, ten round cells.
// Depends on aes_pkg and aes_round_cell.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------
//  input    | in_valid/in_stall| plaintext_high, plaintext_low
//  output   | out_valid/out_stall | ciphertext_high, ciphertext_low
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The block passes the input stage and ten round cells on its way to the output;
// one block per cycle while out_stall does not hold the chain, since all eleven stages hand on together.
// Each round cell carries its own round key alongside the state.
// A stall on the output freezes the whole chain; an empty chain slot is not filled
// either, and in_stall rises only when the last cell holds a stalled result.
// rst clears the valid bits and the key registers.
module aes128_block_encrypt_unit
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] plaintext_high,
  input  logic [63:0] plaintext_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] ciphertext_high,
  output logic [63:0] ciphertext_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  logic [63:0] key_high;
  logic [63:0] key_low;

  logic advance;
  logic v0;
  blk_t s0, k0;

  logic v   [NumRounds+1];
  blk_t st  [NumRounds+1];
  blk_t ky  [NumRounds+1];

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgKeyHigh: key_high <= cfg_data;
        CfgKeyLow:  key_low  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // initial AddRoundKey stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0 <= {plaintext_high, plaintext_low} ^ {key_high, key_low};
      k0 <= {key_high, key_low};
    end
  end

  assign v[0]  = v0;
  assign st[0] = s0;
  assign ky[0] = k0;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .last      (g == NumRounds - 1),
      .rc        (rcon(g + 1)),
      .in_valid  (v[g]),
      .in_state  (st[g]),
      .in_key    (ky[g]),
      .out_valid (v[g+1]),
      .out_state (st[g+1]),
      .out_key   (ky[g+1])
    );
  end

  assign out_valid       = v[NumRounds];
  assign ciphertext_high = st[NumRounds][127:64];
  assign ciphertext_low  = st[NumRounds][63:0];

endmodule

// ----- dv/tb.sv -----
// Testbench for aes128_block_encrypt_unit: AES-128 encryption against an in-bench predictor.
// Depends on aes_pkg (block type) and the RTL top level; checks every ciphertext in order.
module tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KeyHighIdx = 1'b0;
  localparam logic KeyLowIdx  = 1'b1;
  localparam int   PipeDepth  = 11;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] plaintext_high = '0;
  logic [63:0] plaintext_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] ciphertext_high;
  logic [63:0] ciphertext_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = KeyHighIdx;
  logic [63:0] cfg_data = '0;

  logic [127:0] cipher_key;
  blk_t         ciphertext_q[$];
  int           fail_count;
  int           stall_mode;

  aes128_block_encrypt_unit DUT (.*);

  always #5 clk = ~clk;

  // --- predictor ---------------------------------------------------------
  logic [7:0] sbox_lut[256];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box built from the field inverse and the affine map
  task automatic build_sbox();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_lut[x] = s;
    end
  endtask

  function automatic blk_t encrypt_block(input logic [127:0] k, input blk_t pt);
    logic [31:0] w[44];
    logic [31:0] t;
    logic [7:0]  st[16], tmp[16];
    logic [7:0]  rc;
    logic [7:0]  a0, a1, a2, a3, al;
    blk_t        res;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sbox_lut[t[23:16]] ^ rc, sbox_lut[t[15:8]], sbox_lut[t[7:0]],
             sbox_lut[t[31:24]]};
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int n = 0; n < 16; n++) st[n] = pt[127 - 8*n -: 8] ^ w[n/4][31 - 8*(n%4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[c*4 + r] = sbox_lut[st[((c + r) % 4)*4 + r]];
      for (int c = 0; c < 4; c++) begin
        a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
        if (rnd != 10) begin
          al = a0 ^ a1 ^ a2 ^ a3;
          a0 = tmp[c*4]   ^ al ^ gf_mul(tmp[c*4]   ^ tmp[c*4+1], 8'h02);
          a1 = tmp[c*4+1] ^ al ^ gf_mul(tmp[c*4+1] ^ tmp[c*4+2], 8'h02);
          a2 = tmp[c*4+2] ^ al ^ gf_mul(tmp[c*4+2] ^ tmp[c*4+3], 8'h02);
          a3 = tmp[c*4+3] ^ al ^ gf_mul(tmp[c*4+3] ^ tmp[c*4], 8'h02);
        end
        st[c*4] = a0; st[c*4+1] = a1; st[c*4+2] = a2; st[c*4+3] = a3;
      end
      for (int n = 0; n < 16; n++) st[n] ^= w[rnd*4 + n/4][31 - 8*(n%4) -: 8];
    end
    for (int n = 0; n < 16; n++) res[127 - 8*n -: 8] = st[n];
    return res;
  endfunction

  // --- drivers -----------------------------------------------------------
  task automatic write_key_reg(input logic idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == KeyHighIdx) cipher_key[127:64] = val;
    else cipher_key[63:0] = val;
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    in_valid       <= 1'b1;
    plaintext_high <= hi;
    plaintext_low  <= lo;
    do @(posedge clk); while (in_stall);
    ciphertext_q = {ciphertext_q, encrypt_block(cipher_key, {hi, lo})};
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ciphertext_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // burst of random blocks, with random gaps between bursts when gaps is set
  task automatic send_random(input int n, input bit gaps);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (gaps && burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 6));
      end
      burst--;
      send_block(rand64(), rand64());
    end
  endtask

  // --- tests -------------------------------------------------------------
  task automatic test_known_vector();
    write_key_reg(KeyHighIdx, 64'h2b7e151628aed2a6);
    write_key_reg(KeyLowIdx,  64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
    drain();
  endtask

  task automatic test_extremes();
    logic [63:0] pat[4] = '{64'h0, 64'hffffffffffffffff, 64'haaaaaaaaaaaaaaaa,
                            64'h5555555555555555};
    for (int k = 0; k < 4; k++) begin
      write_key_reg(KeyHighIdx, pat[k]);
      write_key_reg(KeyLowIdx, pat[3-k]);
      for (int p = 0; p < 4; p++) send_block(pat[p], pat[(p+k) % 4]);
      // key changes only with the pipe empty
      drain();
    end
  endtask

  task automatic test_random_keys();
    for (int ph = 0; ph < 6; ph++) begin
      write_key_reg(KeyHighIdx, rand64());
      write_key_reg(KeyLowIdx, rand64());
      stall_mode = ph % 3;
      send_random(250, ph != 1);
      drain();
    end
    stall_mode = 0;
  endtask

  // --- result checker and output stall pattern ---------------------------
  always @(posedge clk) begin
    if (!rst) begin
      case (stall_mode)
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= 1'b0;
      endcase
      if (out_valid && !out_stall) begin
        if (ciphertext_q.size() == 0) begin
          $error("unexpected ciphertext %h_%h", ciphertext_high, ciphertext_low);
          fail_count++;
        end else begin
          blk_t exp_ct;
          exp_ct = ciphertext_q.pop_front();
          if (ciphertext_high !== exp_ct[127:64]) begin
            $error("ciphertext_high: expected %h, got %h", exp_ct[127:64], ciphertext_high);
            fail_count++;
          end
          if (ciphertext_low !== exp_ct[63:0]) begin
            $error("ciphertext_low: expected %h, got %h", exp_ct[63:0], ciphertext_low);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  initial begin
    fail_count = 0;
    stall_mode = 0;
    cipher_key = '0;
    build_sbox();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset key is all zeros
    send_block(64'h0, 64'h0);
    drain();
    test_known_vector();
    test_extremes();
    test_random_keys();
    if (ciphertext_q.size() != 0) fail_count++;
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
